[hdl/box_filter_3x3_edge_mean_core_assert.svh]
// assertion helpers for the filter rtl
`ifndef BOX_FILTER_3X3_EDGE_MEAN_CORE_ASSERT_SVH
`define BOX_FILTER_3X3_EDGE_MEAN_CORE_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define BF33_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define BF33_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/bf33_pkg.sv]
package bf33_pkg;

    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int SUM_W       = 12;
    localparam int CNT_W       = 4;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PIX_W-1:0] smoothed;
        logic             eor;
        logic             eof;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             eor;
        logic             eof;
    } mean_req_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } mean_res_t;

    // ceil(2^16 / n); exact floor division for sums below 2^16 / 8
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

[hdl/bf33_line_store.sv]
module bf33_line_store #(
    parameter int MAX_WIDTH = bf33_pkg::DEF_MAX_WIDTH,
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                      aclk,
    input  logic                      rd_en,
    input  logic [AW-1:0]             rd_addr,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [bf33_pkg::PIX_W-1:0] wr_upper,
    input  logic [bf33_pkg::PIX_W-1:0] wr_middle,
    output logic [bf33_pkg::PIX_W-1:0] rd_upper,
    output logic [bf33_pkg::PIX_W-1:0] rd_middle
);
    import bf33_pkg::*;

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [PIX_W-1:0] upper_rd_reg;
    logic [PIX_W-1:0] middle_rd_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_upper_reg;
    logic [PIX_W-1:0] fwd_middle_reg;

    // a read that meets a write to the same entry returns the new data
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            upper_rd_reg   <= upper_mem[rd_addr];
            middle_rd_reg  <= middle_mem[rd_addr];
            fwd_reg        <= wr_en && (wr_addr == rd_addr);
            fwd_upper_reg  <= wr_upper;
            fwd_middle_reg <= wr_middle;
        end
        if (wr_en) begin
            upper_mem[wr_addr]  <= wr_upper;
            middle_mem[wr_addr] <= wr_middle;
        end
    end

    assign rd_upper  = fwd_reg ? fwd_upper_reg  : upper_rd_reg;
    assign rd_middle = fwd_reg ? fwd_middle_reg : middle_rd_reg;

endmodule

[hdl/bf33_mean_div.sv]
module bf33_mean_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bf33_pkg::mean_req_t  req,
    output bf33_pkg::mean_res_t  res
);
    import bf33_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W;

    logic [PROD_W-1:0] prod;
    logic              valid_reg;
    out_item_t         item_reg;

    // floor(sum / cnt) as a multiply by the rounded-up reciprocal
    assign prod = PROD_W'(req.sum) * PROD_W'(recip(req.cnt));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg.smoothed <= prod[RECIP_SHIFT +: PIX_W];
        item_reg.eor      <= req.eor;
        item_reg.eof      <= req.eof;
    end

    assign res.valid = valid_reg;
    assign res.item  = item_reg;

endmodule

[hdl/box_filter_3x3_edge_mean_core.sv]
// 3x3 mean filter with edge handling. Pixels arrive in raster order on the s_ stream
// (tuser = 1 marks a drain transaction); each result is the floor mean of the in-image
// neighbours of one pixel, so borders average 4 or 6 pixels and corners 4, or fewer on
// one-pixel-wide or one-row images. A result leaves after the transaction that comes one
// row plus one pixel behind its centre, so image_width+1 drain transactions must follow
// the last pixel of a frame; tlast marks the end of a row, tuser the end of the frame.
// The block takes one transaction per clock while s_tready is high, ignored drains
// included, and needs no clearing pass after reset. The rate is set by the line stores:
// one read and one write per clock, with write-to-read forwarding for back-to-back use
// of one column. A released result passes the window, sum and divide registers into
// the 8-entry output queue; s_tready drops only when 8 results are queued or still in
// flight. Writing image_width or image_height (at 0x0 and 0x4) restarts the frame.
`include "box_filter_3x3_edge_mean_core_assert.svh"

module box_filter_3x3_edge_mean_core #(
    parameter int MAX_WIDTH  = bf33_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bf33_pkg::DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixels in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel
    input  logic [0:0]  s_tuser,   // [0] opcode
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] smoothed
    output logic        m_tlast,   // end_of_row
    output logic [0:0]  m_tuser    // [0] end_of_frame
);
    import bf33_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT + 2);
    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int OCC_W = FIFO_CW + 1;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] width_raw_reg;
    logic [CFG_W-1:0] height_raw_reg;
    logic             cfg_wr;
    logic [CW-1:0]    w_eff;
    logic [RW-1:0]    h_eff;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_raw_reg  <= SIZE_RESET;
            height_raw_reg <= SIZE_RESET;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(paddr[2]))
                REG_IMAGE_WIDTH:  width_raw_reg  <= pwdata[CFG_W-1:0];
                REG_IMAGE_HEIGHT: height_raw_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg_t'(paddr[2]))
            REG_IMAGE_WIDTH:  prdata = 32'(width_raw_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_raw_reg);
            default:          prdata = '0;
        endcase
    end

    // zero acts as one, oversize as the maximum
    always_comb begin
        if (width_raw_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(width_raw_reg) > MAX_WIDTH) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(width_raw_reg);
        end
        if (height_raw_reg == '0) begin
            h_eff = RW'(1);
        end else if (32'(height_raw_reg) > MAX_HEIGHT) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(height_raw_reg);
        end
    end

    // ---------------- accept stage ----------------
    logic [RW-1:0]    in_row_reg, in_row_next;
    logic [CW-1:0]    in_col_reg, in_col_next;
    logic [RW-1:0]    out_row_reg, out_row_next;
    logic [CW-1:0]    out_col_reg, out_col_next;
    logic             in_acc;
    logic             have_pix;
    logic             a_drop;
    logic             a_emit;
    logic [PIX_W-1:0] a_pix;
    logic             a_left, a_right, a_top, a_bottom;
    logic             a_eor, a_eof;
    logic [OCC_W-1:0] occ;

    assign in_acc   = s_tvalid && s_tready;
    assign have_pix = in_row_reg < h_eff;
    // drains are ignored until the whole frame is in; late pixels act as drains
    assign a_drop   = (op_t'(s_tuser[0]) == OP_DRAIN) && have_pix;
    assign a_pix    = have_pix ? s_tdata : '0;
    assign a_emit   = (in_row_reg >= RW'(2)) || ((in_row_reg == RW'(1)) && (in_col_reg != '0));

    assign a_left   = out_col_reg != '0;
    assign a_right  = (out_col_reg + CW'(1)) < w_eff;
    assign a_top    = out_row_reg != '0;
    assign a_bottom = (out_row_reg + RW'(1)) < h_eff;
    assign a_eor    = !a_right;
    assign a_eof    = a_eor && !a_bottom;

    always_comb begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        if (cfg_wr) begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end else if (in_acc && !a_drop) begin
            if ((in_col_reg + CW'(1)) >= w_eff) begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (a_emit) begin
                if (a_eor) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + RW'(1);
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
                if (a_eof) begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
        end else begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    // ---------------- window stage ----------------
    logic             b_valid_reg;
    logic             b_emit_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [AW-1:0]    b_addr_reg;
    logic [2:0]       b_col_use_reg;
    logic [2:0]       b_row_use_reg;
    logic             b_eor_reg, b_eof_reg;
    logic [PIX_W-1:0] up_eff, mid_eff;
    logic [PIX_W-1:0] win_reg [3][3];
    logic [PIX_W-1:0] cand [3][3];
    logic [SUM_W-1:0] b_sum;
    logic [CNT_W-1:0] b_cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= in_acc && !a_drop && !cfg_wr;
        end
    end

    always_ff @(posedge aclk) begin
        b_emit_reg    <= a_emit;
        b_pix_reg     <= a_pix;
        b_addr_reg    <= in_col_reg[AW-1:0];
        b_col_use_reg <= {a_right, 1'b1, a_left};
        b_row_use_reg <= {a_bottom, 1'b1, a_top};
        b_eor_reg     <= a_eor;
        b_eof_reg     <= a_eof;
    end

    bf33_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk      (aclk),
        .rd_en     (in_acc && !a_drop),
        .rd_addr   (in_col_reg[AW-1:0]),
        .wr_en     (b_valid_reg),
        .wr_addr   (b_addr_reg),
        .wr_upper  (mid_eff),
        .wr_middle (b_pix_reg),
        .rd_upper  (up_eff),
        .rd_middle (mid_eff)
    );

    // window after the shift: centre column is index 1, rows are r-2, r-1, r
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            cand[0][r] = win_reg[1][r];
            cand[1][r] = win_reg[2][r];
        end
        cand[2][0] = up_eff;
        cand[2][1] = mid_eff;
        cand[2][2] = b_pix_reg;
        b_sum = '0;
        b_cnt = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (b_col_use_reg[c] && b_row_use_reg[r]) begin
                    b_sum = b_sum + SUM_W'(cand[c][r]);
                    b_cnt = b_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg) begin
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[c][r] <= cand[c][r];
                end
            end
        end
    end

    // ---------------- sum stage ----------------
    logic      c_valid_reg;
    mean_req_t c_req_reg;
    mean_req_t c_req;
    mean_res_t d_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= b_valid_reg && b_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        c_req_reg.valid <= 1'b0;
        c_req_reg.sum   <= b_sum;
        c_req_reg.cnt   <= b_cnt;
        c_req_reg.eor   <= b_eor_reg;
        c_req_reg.eof   <= b_eof_reg;
    end

    always_comb begin
        c_req       = c_req_reg;
        c_req.valid = c_valid_reg;
    end

    bf33_mean_div u_mean_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (c_req),
        .res     (d_res)
    );

    // ---------------- output queue ----------------
    out_item_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] fifo_cnt_reg, fifo_cnt_next;
    logic               push, pop;

    assign push = d_res.valid;
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        if (push && !pop) begin
            fifo_cnt_next = fifo_cnt_reg + FIFO_CW'(1);
        end else if (pop && !push) begin
            fifo_cnt_next = fifo_cnt_reg - FIFO_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= d_res.item;
        end
    end

    // every result already on its way has a queue slot reserved
    assign occ = OCC_W'(fifo_cnt_reg) + OCC_W'(b_valid_reg && b_emit_reg)
               + OCC_W'(c_valid_reg) + OCC_W'(d_res.valid);
    assign s_tready = occ < OCC_W'(FIFO_DEPTH);

    assign m_tvalid   = fifo_cnt_reg != '0;
    assign m_tdata    = fifo_mem[rd_ptr_reg].smoothed;
    assign m_tlast    = fifo_mem[rd_ptr_reg].eor;
    assign m_tuser[0] = fifo_mem[rd_ptr_reg].eof;

    // ---------------- checks ----------------
    `BF33_ASSERT_NOW(a_occ_bound, 1'b1, occ <= OCC_W'(FIFO_DEPTH), "results in flight overflow queue")
    `BF33_ASSERT_NEXT(a_eof_restart, in_acc && !a_drop && a_emit && a_eof, in_row_reg == '0 && in_col_reg == '0 && out_row_reg == '0 && out_col_reg == '0, "frame end did not restart counters")
    `BF33_ASSERT_NEXT(a_drop_hold, in_acc && a_drop && !cfg_wr, $stable(in_col_reg) && $stable(in_row_reg) && !b_valid_reg, "ignored drain changed state")
    `BF33_ASSERT_NOW(a_eof_is_eor, m_tvalid && m_tuser[0], m_tlast, "frame end without row end")

endmodule
